### rtl/core/etfp_pkg.sv
// Package for the escape-time fractal pixel unit: widths, reset values,
// register indexes, sequencer states and the control structs between modules.
// No dependencies.
`default_nettype none

package etfp_pkg;

   // Fixed-point format and field widths
   localparam int COORD_FRAC_BITS = 28;
   localparam int COUNT_BITS      = 16;
   localparam int DIM_BITS        = 12;
   localparam int COORD_W         = 32;
   localparam int DIM_REG_W       = 13;

   // CSR port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = COORD_W;

   // Coordinate mapping: span, quotient, divisor and sum widths
   localparam int DIFF_W    = COORD_W + 1;
   localparam int QUO_W     = DIFF_W + DIM_BITS;
   localparam int DEN_W     = DIM_REG_W;
   localparam int MAP_W     = QUO_W + 2;
   localparam int DIV_CNT_W = $clog2(QUO_W + 1);

   // Orbit datapath: z register, multiplier operand and product widths
   localparam int Z_W    = ((COORD_W > COORD_FRAC_BITS + 2) ?
                            COORD_W : COORD_FRAC_BITS + 2) + 2;
   localparam int OP_W   = COORD_FRAC_BITS + 3;
   localparam int PROD_W = COORD_FRAC_BITS + Z_W;

   // 2.0 and 4.0 in the z format
   localparam logic signed [Z_W-1:0] ESC_TWO =
      {{(Z_W-COORD_FRAC_BITS-2){1'b0}}, 2'b10, {COORD_FRAC_BITS{1'b0}}};
   localparam logic signed [Z_W-1:0] ESC_FOUR =
      {{(Z_W-COORD_FRAC_BITS-3){1'b0}}, 3'b100, {COORD_FRAC_BITS{1'b0}}};

   // Saturation bounds of a mapped coordinate
   localparam logic signed [MAP_W-1:0] MAP_MAX =
      {{(MAP_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
   localparam logic signed [MAP_W-1:0] MAP_MIN =
      {{(MAP_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

   // CSR reset values
   localparam logic signed [COORD_W-1:0] X_MIN_RST = COORD_W'(-644245094);
   localparam logic signed [COORD_W-1:0] X_MAX_RST = COORD_W'(268435456);
   localparam logic signed [COORD_W-1:0] Y_MIN_RST = COORD_W'(-342255206);
   localparam logic signed [COORD_W-1:0] Y_MAX_RST = COORD_W'(342255206);
   localparam logic [DIM_REG_W-1:0]      IMAGE_WIDTH_RST  = DIM_REG_W'(800);
   localparam logic [DIM_REG_W-1:0]      IMAGE_HEIGHT_RST = DIM_REG_W'(600);
   localparam logic [COUNT_BITS-1:0]     ITER_LIMIT_RST   = COUNT_BITS'(256);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_MIN,
      CSR_X_MAX,
      CSR_Y_MIN,
      CSR_Y_MAX,
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_ITER_LIMIT
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_START,
      ST_DIV,
      ST_ADD,
      ST_ORBIT_START,
      ST_ORBIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic start;
   } orbit_ctrl_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic                  in_set;
      logic [COUNT_BITS-1:0] count;
   } orbit_stat_type;

endpackage

`default_nettype wire

### rtl/core/etfp_if.sv
// Request and response channel interfaces of the escape-time fractal pixel unit.
// Depends on etfp_pkg.
`default_nettype none

interface etfp_req_if;
   logic                         valid;
   logic                         ready;
   logic [etfp_pkg::DIM_BITS-1:0] column;
   logic [etfp_pkg::DIM_BITS-1:0] row;

   modport source (output valid, output column, output row, input ready);
   modport sink   (input valid, input column, input row, output ready);
endinterface

interface etfp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [etfp_pkg::COUNT_BITS-1:0] escape_count;
   logic                           inside_set;
   logic [etfp_pkg::DIM_BITS-1:0]   pixel_column;
   logic [etfp_pkg::DIM_BITS-1:0]   pixel_row;

   modport source (output valid, output escape_count, output inside_set,
                   output pixel_column, output pixel_row, input ready);
   modport sink   (input valid, input escape_count, input inside_set,
                   input pixel_column, input pixel_row, output ready);
endinterface

`default_nettype wire

### rtl/core/escape_time_fractal_pixel_unit.sv
// Escape-time fractal (Mandelbrot) pixel unit. Each request carries a pixel
// column and row; the unit maps them linearly onto the window set by the CSRs
// (signed Q4.28), iterates z = z*z + c from z = 0 and answers with the escape
// count, the inside-set flag and the pixel position. One request is handled at
// a time. The fixed part of its time comes from the restoring divider, which
// makes one quotient bit a cycle for each axis of the mapping; the rest is
// the orbit unit, which runs one iteration per cycle. A finished response
// waits in its output register while the next request is taken. The user
// must write the CSRs only while no request is in flight; the unit itself
// does not enforce this.
// Depends on etfp_pkg, etfp_if, etfp_div and etfp_orbit.
`default_nettype none

module escape_time_fractal_pixel_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   etfp_req_if.sink                               req_ch,
   etfp_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_wr_en,
   input  wire logic [etfp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [etfp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CW = etfp_pkg::COORD_W;
   localparam int MW = etfp_pkg::MAP_W;

   // ---------------------------------------------------------------- CSRs
   logic signed [CW-1:0]              x_min_ff, x_min_in;
   logic signed [CW-1:0]              x_max_ff, x_max_in;
   logic signed [CW-1:0]              y_min_ff, y_min_in;
   logic signed [CW-1:0]              y_max_ff, y_max_in;
   logic [etfp_pkg::DIM_REG_W-1:0]    image_width_ff, image_width_in;
   logic [etfp_pkg::DIM_REG_W-1:0]    image_height_ff, image_height_in;
   logic [etfp_pkg::COUNT_BITS-1:0]   iteration_limit_ff, iteration_limit_in;

   always_comb begin
      x_min_in           = x_min_ff;
      x_max_in           = x_max_ff;
      y_min_in           = y_min_ff;
      y_max_in           = y_max_ff;
      image_width_in     = image_width_ff;
      image_height_in    = image_height_ff;
      iteration_limit_in = iteration_limit_ff;
      if (csr_wr_en) begin
         case (etfp_pkg::csr_index_type'(csr_index))
            etfp_pkg::CSR_X_MIN:        x_min_in = csr_wdata;
            etfp_pkg::CSR_X_MAX:        x_max_in = csr_wdata;
            etfp_pkg::CSR_Y_MIN:        y_min_in = csr_wdata;
            etfp_pkg::CSR_Y_MAX:        y_max_in = csr_wdata;
            etfp_pkg::CSR_IMAGE_WIDTH:  image_width_in = csr_wdata[etfp_pkg::DIM_REG_W-1:0];
            etfp_pkg::CSR_IMAGE_HEIGHT: image_height_in = csr_wdata[etfp_pkg::DIM_REG_W-1:0];
            etfp_pkg::CSR_ITER_LIMIT:   iteration_limit_in = csr_wdata[etfp_pkg::COUNT_BITS-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------- sequencer
   etfp_pkg::state_type       state_ff, state_in;
   etfp_pkg::div_ctrl_type    div_ctrl;
   etfp_pkg::div_stat_type    div_stat;
   etfp_pkg::orbit_ctrl_type  orbit_ctrl;
   etfp_pkg::orbit_stat_type  orbit_stat;

   logic req_ready;
   logic accept;
   logic mul_load;
   logic c_load;
   logic rsp_load;
   logic rsp_valid_ff, rsp_valid_in;
   logic axis_ff, axis_in;          // 0: real axis, 1: imaginary axis

   assign accept = req_ch.valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         etfp_pkg::ST_IDLE:        if (req_ch.valid) state_in = etfp_pkg::ST_MUL;
         etfp_pkg::ST_MUL:         state_in = etfp_pkg::ST_DIV_START;
         etfp_pkg::ST_DIV_START:   state_in = etfp_pkg::ST_DIV;
         etfp_pkg::ST_DIV:         if (div_stat.done) state_in = etfp_pkg::ST_ADD;
         etfp_pkg::ST_ADD: begin
            state_in = axis_ff ? etfp_pkg::ST_ORBIT_START : etfp_pkg::ST_MUL;
         end
         etfp_pkg::ST_ORBIT_START: state_in = etfp_pkg::ST_ORBIT;
         etfp_pkg::ST_ORBIT:       if (orbit_stat.done) state_in = etfp_pkg::ST_DONE;
         etfp_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = etfp_pkg::ST_IDLE;
         end
         default:                  state_in = etfp_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready        = 1'b0;
      mul_load         = 1'b0;
      div_ctrl.start   = 1'b0;
      c_load           = 1'b0;
      orbit_ctrl.start = 1'b0;
      rsp_load         = 1'b0;
      case (state_ff)
         etfp_pkg::ST_IDLE:        req_ready = 1'b1;
         etfp_pkg::ST_MUL:         mul_load = 1'b1;
         etfp_pkg::ST_DIV_START:   div_ctrl.start = 1'b1;
         etfp_pkg::ST_ADD:         c_load = 1'b1;
         etfp_pkg::ST_ORBIT_START: orbit_ctrl.start = 1'b1;
         etfp_pkg::ST_DONE:        rsp_load = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   assign req_ch.ready = req_ready;

   // ------------------------------------------------------ coordinate map
   // c = lo + (idx * (hi - lo)) / (dim - 1), quotient truncated toward zero,
   // done as sign * (|idx * span| / den) and saturated to 32 bits.
   logic [etfp_pkg::DIM_BITS-1:0]     col_ff, col_in;
   logic [etfp_pkg::DIM_BITS-1:0]     row_ff, row_in;
   logic [etfp_pkg::QUO_W-1:0]        prod_ff, prod_in;
   logic                              neg_ff, neg_in;
   logic [etfp_pkg::DEN_W-1:0]        den_ff, den_in;
   logic signed [CW-1:0]              cx_ff, cx_in;
   logic signed [CW-1:0]              cy_ff, cy_in;

   logic signed [CW-1:0]              lo_sel, hi_sel;
   logic [etfp_pkg::DIM_BITS-1:0]     idx_sel;
   logic [etfp_pkg::DEN_W-1:0]        dim_sel;
   logic signed [etfp_pkg::DIFF_W-1:0] span;
   logic [etfp_pkg::DIFF_W-1:0]       span_mag;
   logic [etfp_pkg::QUO_W-1:0]        quotient;
   logic signed [MW-1:0]              q_ext, q_signed, lo_ext, mapped;
   logic signed [CW-1:0]              c_sat;

   assign lo_sel  = axis_ff ? y_min_ff : x_min_ff;
   assign hi_sel  = axis_ff ? y_max_ff : x_max_ff;
   assign idx_sel = axis_ff ? row_ff : col_ff;
   assign dim_sel = axis_ff ? image_height_ff : image_width_ff;

   assign span     = {hi_sel[CW-1], hi_sel} - {lo_sel[CW-1], lo_sel};
   assign span_mag = span[etfp_pkg::DIFF_W-1] ? etfp_pkg::DIFF_W'(-span)
                                              : etfp_pkg::DIFF_W'(span);

   assign q_ext    = {{(MW-etfp_pkg::QUO_W){1'b0}}, quotient};
   assign q_signed = neg_ff ? -q_ext : q_ext;
   assign lo_ext   = {{(MW-CW){lo_sel[CW-1]}}, lo_sel};
   assign mapped   = lo_ext + q_signed;

   always_comb begin
      if (mapped > etfp_pkg::MAP_MAX)      c_sat = etfp_pkg::MAP_MAX[CW-1:0];
      else if (mapped < etfp_pkg::MAP_MIN) c_sat = etfp_pkg::MAP_MIN[CW-1:0];
      else                                 c_sat = mapped[CW-1:0];
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      axis_in = axis_ff;
      prod_in = prod_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      if (accept) begin
         col_in  = req_ch.column;
         row_in  = req_ch.row;
         axis_in = 1'b0;
      end
      if (mul_load) begin
         prod_in = {{(etfp_pkg::QUO_W-etfp_pkg::DIFF_W){1'b0}}, span_mag} *
                   {{(etfp_pkg::QUO_W-etfp_pkg::DIM_BITS){1'b0}}, idx_sel};
         neg_in  = span[etfp_pkg::DIFF_W-1];
         // a dimension below 2 acts as 2
         den_in  = (dim_sel < etfp_pkg::DEN_W'(2)) ? etfp_pkg::DEN_W'(1)
                                                   : dim_sel - etfp_pkg::DEN_W'(1);
      end
      if (c_load) begin
         axis_in = 1'b1;
         if (axis_ff) cy_in = c_sat;
         else         cx_in = c_sat;
      end
   end

   etfp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_ctrl (div_ctrl),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .div_stat (div_stat),
      .quotient (quotient)
   );

   // ---------------------------------------------------------- orbit
   etfp_orbit u_orbit (
      .clock      (clock),
      .reset      (reset),
      .orbit_ctrl (orbit_ctrl),
      .cx         (cx_ff),
      .cy         (cy_ff),
      .limit      (iteration_limit_ff),
      .orbit_stat (orbit_stat)
   );

   // ------------------------------------------------------ response reg
   logic [etfp_pkg::COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                            rsp_inside_ff, rsp_inside_in;
   logic [etfp_pkg::DIM_BITS-1:0]   rsp_col_ff, rsp_col_in;
   logic [etfp_pkg::DIM_BITS-1:0]   rsp_row_ff, rsp_row_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_count_in  = rsp_count_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_count_in  = orbit_stat.count;
         rsp_inside_in = orbit_stat.in_set;
         rsp_col_in    = col_ff;
         rsp_row_in    = row_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.escape_count = rsp_count_ff;
   assign rsp_ch.inside_set   = rsp_inside_ff;
   assign rsp_ch.pixel_column = rsp_col_ff;
   assign rsp_ch.pixel_row    = rsp_row_ff;

   // ---------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff           <= etfp_pkg::X_MIN_RST;
         x_max_ff           <= etfp_pkg::X_MAX_RST;
         y_min_ff           <= etfp_pkg::Y_MIN_RST;
         y_max_ff           <= etfp_pkg::Y_MAX_RST;
         image_width_ff     <= etfp_pkg::IMAGE_WIDTH_RST;
         image_height_ff    <= etfp_pkg::IMAGE_HEIGHT_RST;
         iteration_limit_ff <= etfp_pkg::ITER_LIMIT_RST;
         state_ff           <= etfp_pkg::ST_IDLE;
         axis_ff            <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         x_min_ff           <= x_min_in;
         x_max_ff           <= x_max_in;
         y_min_ff           <= y_min_in;
         y_max_ff           <= y_max_in;
         image_width_ff     <= image_width_in;
         image_height_ff    <= image_height_in;
         iteration_limit_ff <= iteration_limit_in;
         state_ff           <= state_in;
         axis_ff            <= axis_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      col_ff        <= col_in;
      row_ff        <= row_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      den_ff        <= den_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
   end

   // ---------------------------------------------------------- checks
   a_accept_starts_map: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == etfp_pkg::ST_MUL)
      else $error("accepted request did not start the mapping");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == etfp_pkg::ST_DONE))
      else $error("response raised outside the done state");

   a_div_busy_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == etfp_pkg::ST_DIV)
      else $error("divider running outside the divide state");

   a_add_after_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == etfp_pkg::ST_ADD |-> $past(div_stat.done))
      else $error("coordinate add without a finished division");

   a_orbit_busy_in_orbit: assert property (@(posedge clock) disable iff (reset)
      orbit_stat.busy |-> state_ff == etfp_pkg::ST_ORBIT)
      else $error("orbit unit running outside the orbit state");

endmodule

`default_nettype wire

### rtl/core/etfp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on etfp_pkg.
`default_nettype none

module etfp_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire etfp_pkg::div_ctrl_type       div_ctrl,
   input  wire logic [etfp_pkg::QUO_W-1:0]   dividend,
   input  wire logic [etfp_pkg::DEN_W-1:0]   divisor,
   output etfp_pkg::div_stat_type            div_stat,
   output logic [etfp_pkg::QUO_W-1:0]        quotient
);

   logic [etfp_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [etfp_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [etfp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [etfp_pkg::DEN_W:0] shifted;
   logic [etfp_pkg::DEN_W:0] trial;
   logic                     fits;

   assign shifted = {rem_ff, quo_ff[etfp_pkg::QUO_W-1]};
   assign fits    = shifted >= {1'b0, divisor};
   assign trial   = shifted - {1'b0, divisor};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_ctrl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = etfp_pkg::DIV_CNT_W'(etfp_pkg::QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial[etfp_pkg::DEN_W-1:0] : shifted[etfp_pkg::DEN_W-1:0];
         quo_in = {quo_ff[etfp_pkg::QUO_W-2:0], fits};
         cnt_in = cnt_ff - etfp_pkg::DIV_CNT_W'(1);
         if (cnt_ff == etfp_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = done_ff;
   assign quotient      = quo_ff;

endmodule

`default_nettype wire

### rtl/core/etfp_orbit.sv
// Orbit unit: one z = z*z + c step with escape test per cycle.
// Depends on etfp_pkg.
`default_nettype none

module etfp_orbit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire etfp_pkg::orbit_ctrl_type             orbit_ctrl,
   input  wire logic signed [etfp_pkg::COORD_W-1:0]  cx,
   input  wire logic signed [etfp_pkg::COORD_W-1:0]  cy,
   input  wire logic [etfp_pkg::COUNT_BITS-1:0]      limit,
   output etfp_pkg::orbit_stat_type                  orbit_stat
);

   localparam int FB = etfp_pkg::COORD_FRAC_BITS;

   logic signed [etfp_pkg::Z_W-1:0]    x_ff, x_in;
   logic signed [etfp_pkg::Z_W-1:0]    y_ff, y_in;
   logic [etfp_pkg::COUNT_BITS-1:0]    iter_ff, iter_in;
   logic                               run_ff, run_in;
   logic                               done_ff, done_in;
   logic                               inside_ff, inside_in;

   logic signed [etfp_pkg::PROD_W-1:0] x_ext, y_ext;
   logic signed [etfp_pkg::PROD_W-1:0] xx_p, yy_p, xy_p, xy_adj;
   logic [etfp_pkg::PROD_W-1:0]        xy_rnd;
   logic signed [etfp_pkg::Z_W-1:0]    xx_q, yy_q, xy_q, sum_sq;
   logic signed [etfp_pkg::Z_W-1:0]    cx_ext, cy_ext, x_next, y_next;
   logic                               escaped;

   // Operands are only meaningful while |x|,|y| <= 2; larger values escape
   // on the magnitude test and the products are then ignored.
   assign x_ext = {{(etfp_pkg::PROD_W-etfp_pkg::OP_W){x_ff[etfp_pkg::OP_W-1]}},
                   x_ff[etfp_pkg::OP_W-1:0]};
   assign y_ext = {{(etfp_pkg::PROD_W-etfp_pkg::OP_W){y_ff[etfp_pkg::OP_W-1]}},
                   y_ff[etfp_pkg::OP_W-1:0]};

   assign xx_p = x_ext * x_ext;
   assign yy_p = y_ext * y_ext;
   assign xy_p = x_ext * y_ext;

   // squares are non-negative; the cross product rounds toward zero
   assign xy_rnd = {{(etfp_pkg::PROD_W-FB){1'b0}}, {FB{xy_p[etfp_pkg::PROD_W-1]}}};
   assign xy_adj = xy_p + xy_rnd;

   assign xx_q = xx_p[FB +: etfp_pkg::Z_W];
   assign yy_q = yy_p[FB +: etfp_pkg::Z_W];
   assign xy_q = xy_adj[FB +: etfp_pkg::Z_W];

   assign sum_sq  = xx_q + yy_q;
   assign escaped = (x_ff > etfp_pkg::ESC_TWO) || (x_ff < -etfp_pkg::ESC_TWO) ||
                    (y_ff > etfp_pkg::ESC_TWO) || (y_ff < -etfp_pkg::ESC_TWO) ||
                    (sum_sq > etfp_pkg::ESC_FOUR);

   assign cx_ext = {{(etfp_pkg::Z_W-etfp_pkg::COORD_W){cx[etfp_pkg::COORD_W-1]}}, cx};
   assign cy_ext = {{(etfp_pkg::Z_W-etfp_pkg::COORD_W){cy[etfp_pkg::COORD_W-1]}}, cy};
   assign x_next = xx_q - yy_q + cx_ext;
   assign y_next = {xy_q[etfp_pkg::Z_W-2:0], 1'b0} + cy_ext;

   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      iter_in   = iter_ff;
      run_in    = run_ff;
      inside_in = inside_ff;
      done_in   = 1'b0;
      if (orbit_ctrl.start) begin
         x_in    = '0;
         y_in    = '0;
         iter_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (iter_ff == limit) begin
            run_in    = 1'b0;
            done_in   = 1'b1;
            inside_in = 1'b1;
         end else if (escaped) begin
            run_in    = 1'b0;
            done_in   = 1'b1;
            inside_in = 1'b0;
         end else begin
            x_in    = x_next;
            y_in    = y_next;
            iter_in = iter_ff + etfp_pkg::COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      iter_ff   <= iter_in;
      inside_ff <= inside_in;
   end

   assign orbit_stat.busy   = run_ff;
   assign orbit_stat.done   = done_ff;
   assign orbit_stat.in_set = inside_ff;
   assign orbit_stat.count  = iter_ff;

endmodule

`default_nettype wire

### dv/tb_escape_time_fractal_pixel_unit.sv
// Self-checking testbench for escape_time_fractal_pixel_unit: directed and random
// pixel requests checked against an in-bench Q4.28 escape-time predictor.
// Depends on etfp_pkg, etfp_if and the unit itself.
`default_nettype none

module tb_escape_time_fractal_pixel_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import etfp_pkg::*;

   // Quiet cycles allowed with nothing accepted on either channel. The slowest
   // legal request is an inside point at a limit of 65535.
   localparam int unsigned WATCHDOG_LIMIT = 200000;
   localparam int unsigned SETTLE_CYCLES  = 400;
   localparam int unsigned IDLE_PERCENT   = 11;

   localparam logic [63:0] ESCAPE_TWO  = 64'd2 << COORD_FRAC_BITS;
   localparam logic [63:0] ESCAPE_FOUR = 64'd4 << COORD_FRAC_BITS;
   localparam logic [127:0] PRODUCT_CAP = 128'd1 << 62;
   localparam longint COORD_MAX = 64'sd2147483647;
   localparam longint COORD_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [COUNT_BITS-1:0] escape_count;
      logic                  inside_set;
      logic [DIM_BITS-1:0]   pixel_column;
      logic [DIM_BITS-1:0]   pixel_row;
   } pixel_result_t;

   logic clock;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   etfp_req_if req_ch ();
   etfp_rsp_if rsp_ch ();

   escape_time_fractal_pixel_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the window and limit registers, updated on every CSR write
   logic signed [COORD_W-1:0]   win_x_min;
   logic signed [COORD_W-1:0]   win_x_max;
   logic signed [COORD_W-1:0]   win_y_min;
   logic signed [COORD_W-1:0]   win_y_max;
   logic [DIM_REG_W-1:0]        img_width;
   logic [DIM_REG_W-1:0]        img_height;
   logic [COUNT_BITS-1:0]       iter_limit;

   // Expected pixel results in request order
   pixel_result_t pending_pixels[$];

   int unsigned mismatch_count;
   int unsigned requests_sent;
   int unsigned results_checked;
   int unsigned inside_results;
   int unsigned quiet_cycles;
   logic        idle_on;

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   function automatic logic [63:0] abs_u64(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   // Exact product, magnitude shifted right by the fraction bits (toward zero),
   // magnitude capped at 2^62.
   function automatic longint q28_mul(input longint a, input longint b);
      logic [127:0] prod;
      logic [63:0]  mag;
      prod = {64'd0, abs_u64(a)} * {64'd0, abs_u64(b)};
      prod = prod >> COORD_FRAC_BITS;
      if (prod > PRODUCT_CAP)
         prod = PRODUCT_CAP;
      mag = prod[63:0];
      return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
   endfunction

   // Linear pixel-to-plane mapping; dims below 2 act as 2, result saturates to
   // the signed 32-bit range for pixels outside the image.
   function automatic longint map_axis(input longint lo, input longint hi,
                                       input logic [DIM_BITS-1:0] idx,
                                       input logic [DIM_REG_W-1:0] dim);
      longint den;
      longint v;
      den = (dim < 2) ? 64'sd1 : longint'(dim) - 1;
      v = lo + (longint'(idx) * (hi - lo)) / den;
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return v;
   endfunction

   function automatic pixel_result_t predict_pixel(input logic [DIM_BITS-1:0] col,
                                                   input logic [DIM_BITS-1:0] row);
      pixel_result_t res;
      longint cx, cy, x, y, xx, yy, xy;
      logic [63:0] sq_sum;
      int unsigned step;
      logic escaped;
      cx = map_axis(longint'(win_x_min), longint'(win_x_max), col, img_width);
      cy = map_axis(longint'(win_y_min), longint'(win_y_max), row, img_height);
      x = 0;
      y = 0;
      step = 0;
      escaped = 1'b0;
      // Escape test precedes each iteration; a component above 2 escapes at once
      while (!escaped && step < iter_limit) begin
         if (abs_u64(x) > ESCAPE_TWO || abs_u64(y) > ESCAPE_TWO) begin
            escaped = 1'b1;
         end else begin
            xx = q28_mul(x, x);
            yy = q28_mul(y, y);
            sq_sum = xx + yy;
            if (sq_sum > ESCAPE_FOUR) begin
               escaped = 1'b1;
            end else begin
               xy = q28_mul(x, y);
               x = xx - yy + cx;
               y = 2 * xy + cy;
               step++;
            end
         end
      end
      res.escape_count = step[COUNT_BITS-1:0];
      res.inside_set   = !escaped;
      res.pixel_column = col;
      res.pixel_row    = row;
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   // One register write; the unit is idle whenever this is called.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_X_MIN:        win_x_min  = data;
         CSR_X_MAX:        win_x_max  = data;
         CSR_Y_MIN:        win_y_min  = data;
         CSR_Y_MAX:        win_y_max  = data;
         CSR_IMAGE_WIDTH:  img_width  = data[DIM_REG_W-1:0];
         CSR_IMAGE_HEIGHT: img_height = data[DIM_REG_W-1:0];
         CSR_ITER_LIMIT:   iter_limit = data[COUNT_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_window(input longint x_lo, input longint x_hi,
                               input longint y_lo, input longint y_hi);
      write_csr(CSR_X_MIN, 32'(x_lo));
      write_csr(CSR_X_MAX, 32'(x_hi));
      write_csr(CSR_Y_MIN, 32'(y_lo));
      write_csr(CSR_Y_MAX, 32'(y_hi));
   endtask

   task automatic write_dims(input int unsigned w, input int unsigned h,
                             input int unsigned lim);
      write_csr(CSR_IMAGE_WIDTH, 32'(w));
      write_csr(CSR_IMAGE_HEIGHT, 32'(h));
      write_csr(CSR_ITER_LIMIT, 32'(lim));
   endtask

   // Present one pixel request, hold it until accepted, then record the
   // expected result. Valid is left high so back-to-back requests need no gap.
   task automatic send_pixel(input logic [DIM_BITS-1:0] col,
                             input logic [DIM_BITS-1:0] row);
      int unsigned gap;
      if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         // mostly short gaps, now and then one long enough to span an orbit
         gap = ($urandom_range(7) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 3);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid  <= 1'b1;
      req_ch.column <= col;
      req_ch.row    <= row;
      do @(posedge clock); while (!req_ch.ready);
      pending_pixels.push_back(predict_pixel(col, row));
      requests_sent++;
   endtask

   // Lower valid and wait for every outstanding pixel to come back.
   task automatic drain_pixels();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Response-side stalls
   always @(negedge clock)
      rsp_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);

   // ---------------------------------------------------------------------------
   // Result checker: every accepted response against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_result_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("response (%0d,%0d) with no request pending",
                                      rsp_ch.pixel_column, rsp_ch.pixel_row));
         end else begin
            want = pending_pixels.pop_front();
            results_checked++;
            if (want.inside_set) inside_results++;
            if (rsp_ch.escape_count !== want.escape_count)
               report_mismatch($sformatf("pixel (%0d,%0d) escape_count %0d, expected %0d",
                  want.pixel_column, want.pixel_row, rsp_ch.escape_count,
                  want.escape_count));
            if (rsp_ch.inside_set !== want.inside_set)
               report_mismatch($sformatf("pixel (%0d,%0d) inside_set %b, expected %b",
                  want.pixel_column, want.pixel_row, rsp_ch.inside_set, want.inside_set));
            if (rsp_ch.pixel_column !== want.pixel_column)
               report_mismatch($sformatf("pixel_column %0d, expected %0d",
                  rsp_ch.pixel_column, want.pixel_column));
            if (rsp_ch.pixel_row !== want.pixel_row)
               report_mismatch($sformatf("pixel_row %0d, expected %0d",
                  rsp_ch.pixel_row, want.pixel_row));
         end
      end
   end

   // Watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no handshake for %0d cycles, %0d results outstanding",
                  $realtime, quiet_cycles, pending_pixels.size());
         $display("escape_time_fractal_pixel_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset window: image corners, a point near the origin (inside), and the
   // largest column/row, which extrapolate past the window.
   task automatic test_reset_window();
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd799, 12'd599);
      send_pixel(12'd564, 12'd300);
      send_pixel(12'd4095, 12'd4095);
      drain_pixels();
   endtask

   // Iteration limit of zero, one and the maximum.
   task automatic test_iteration_limits();
      write_csr(CSR_ITER_LIMIT, 32'd0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd564, 12'd300);
      drain_pixels();
      write_csr(CSR_ITER_LIMIT, 32'd1);
      send_pixel(12'd0, 12'd0);
      drain_pixels();
      // full 16-bit limit: one fast escape, one point that runs the whole orbit
      write_csr(CSR_ITER_LIMIT, 32'hFFFF);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd564, 12'd300);
      drain_pixels();
   endtask

   // Image dimensions of 0 and 1 (treated as 2) and beyond the pixel range.
   task automatic test_image_dims();
      write_dims(0, 1, 32);
      send_pixel(12'd1, 12'd1);
      send_pixel(12'd3, 12'd2);
      drain_pixels();
      write_dims(1, 0, 32);
      send_pixel(12'd0, 12'd1);
      drain_pixels();
      write_dims(8191, 4096, 32);
      send_pixel(12'd4095, 12'd4095);
      drain_pixels();
   endtask

   // Full-range and reversed windows: spans need 33 bits, c saturates.
   task automatic test_window_extremes();
      write_window(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
      write_dims(2, 2, 8);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1, 12'd1);
      send_pixel(12'd4095, 12'd4095);
      drain_pixels();
      write_window(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
      send_pixel(12'd4095, 12'd0);
      drain_pixels();
   endtask

   // Random phases: new window, size and limit per phase, then a burst of
   // pixels. Most windows sit on the interesting part of the set so orbits
   // run long; a few are fully random. Two phases run without any idling.
   task automatic test_random_frames();
      longint center_x, center_y, span_x, span_y, lo_x, hi_x, lo_y, hi_y;
      int unsigned w, h, lim, phase, k;
      logic [DIM_BITS-1:0] col, row;
      for (phase = 0; phase < 10; phase++) begin
         idle_on = !(phase == 0 || phase == 5);
         if ($urandom_range(7) == 0) begin
            lo_x = longint'(signed'($urandom));
            hi_x = longint'(signed'($urandom));
            lo_y = longint'(signed'($urandom));
            hi_y = longint'(signed'($urandom));
         end else begin
            center_x = longint'($urandom_range(0, 671088640)) - 536870912;
            center_y = longint'($urandom_range(0, 536870912)) - 268435456;
            span_x   = longint'($urandom_range(1 << 18, 1 << 30));
            span_y   = longint'($urandom_range(1 << 18, 1 << 30));
            lo_x = center_x - span_x / 2;
            hi_x = center_x + span_x / 2;
            lo_y = center_y - span_y / 2;
            hi_y = center_y + span_y / 2;
            // occasionally mirror an axis
            if ($urandom_range(5) == 0) begin
               center_x = lo_x;
               lo_x = hi_x;
               hi_x = center_x;
            end
         end
         write_window(lo_x, hi_x, lo_y, hi_y);
         if ($urandom_range(7) == 0) begin
            w = $urandom_range(0, 8191);
            h = $urandom_range(0, 8191);
         end else begin
            w = $urandom_range(2, 4096);
            h = $urandom_range(2, 4096);
         end
         lim = ($urandom_range(5) == 0) ? $urandom_range(65, 400) : $urandom_range(1, 64);
         write_dims(w, h, lim);
         for (k = 0; k < 100; k++) begin
            if ($urandom_range(9) == 0 || w < 2 || h < 2) begin
               col = DIM_BITS'($urandom);
               row = DIM_BITS'($urandom);
            end else begin
               col = DIM_BITS'($urandom_range(0, (w > 4096 ? 4096 : w) - 1));
               row = DIM_BITS'($urandom_range(0, (h > 4096 ? 4096 : h) - 1));
            end
            send_pixel(col, row);
         end
         drain_pixels();
      end
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_X_MIN;
      csr_wdata = '0;
      req_ch.valid  = 1'b0;
      req_ch.column = '0;
      req_ch.row    = '0;
      rsp_ch.ready  = 1'b0;
      idle_on = 1'b1;
      mismatch_count  = 0;
      requests_sent   = 0;
      results_checked = 0;
      inside_results  = 0;
      quiet_cycles    = 0;
      win_x_min  = X_MIN_RST;
      win_x_max  = X_MAX_RST;
      win_y_min  = Y_MIN_RST;
      win_y_max  = Y_MAX_RST;
      img_width  = IMAGE_WIDTH_RST;
      img_height = IMAGE_HEIGHT_RST;
      iter_limit = ITER_LIMIT_RST;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_window();
      test_iteration_limits();
      test_image_dims();
      test_window_extremes();
      test_random_frames();

      // catch any stray response after the queue has emptied
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("checked %0d of %0d pixel requests: %0d inside the set, %0d escaped",
               results_checked, requests_sent, inside_results,
               results_checked - inside_results);
      $display("limits 0, 1, 65535 and random; degenerate, oversized, full-range windows");
      if (mismatch_count == 0) begin
         $display("escape_time_fractal_pixel_unit regression: pass");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("escape_time_fractal_pixel_unit regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
